/* src/tfa_pkg.sv */
package tfa_pkg;

  // Default build of the block.
  localparam int MAX_FRAMES_DEF  = 8;
  localparam int FRAME_BYTES_DEF = 262144;

  // frames_in_use after reset, before clamping to MAX_FRAMES.
  localparam int FRAMES_RESET = 8;

  // Upper ends of the parameter ranges. The descriptor fields are sized for them.
  localparam int MAX_FRAMES_LIM = 16;
  localparam int IDX_MAX_W      = 22;
  localparam int SLOT_MAX_W     = 4;
  localparam int CNT_MAX_W      = 5;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 4;
  localparam int HELD_OUT_W  = 4;
  localparam int OUT_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 4;

  // What travels with an item all the way to the result.
  typedef struct packed {
    logic [CNT_MAX_W-1:0] count;
    logic                 full;
    logic                 eof;
  } tfa_tag_t;

  // One classified pixel, handed from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]          pixel;
    logic [IDX_MAX_W-1:0]      index;
    logic [SLOT_MAX_W-1:0]     slot;
    logic [MAX_FRAMES_LIM-1:0] use_mask;
    tfa_tag_t                  tag;
  } tfa_desc_t;

endpackage

/* src/tfa_ram.sv */
module tfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tfa_front.sv */
module tfa_front
  import tfa_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,
  input  logic             in_tlast,
  input  logic             in_tuser,
  input  logic             q_ready,
  output logic             q_push,
  output tfa_desc_t        q_desc
);

  localparam int NW      = $clog2(MAX_FRAMES + 1);
  localparam int SW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int IW      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LW      = $clog2(FRAME_BYTES + 1);
  localparam int FIU_RST = (FRAMES_RESET < MAX_FRAMES) ? FRAMES_RESET : MAX_FRAMES;

  logic [NW-1:0] fiu_r,   fiu_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [NW-1:0] held_r,  held_nxt;
  logic [IW-1:0] idx_r,   idx_nxt;
  logic [LW-1:0] slot_len_r   [MAX_FRAMES];
  logic [LW-1:0] slot_len_nxt [MAX_FRAMES];

  logic                  accept;
  logic                  clr_eff;
  logic [SW-1:0]         ws;
  logic [NW-1:0]         hc;
  logic [NW:0]           hc_inc;
  logic [NW-1:0]         n;
  logic                  full;
  logic [MAX_FRAMES-1:0] mask;
  logic [CFG_W:0]        cfg_ext;
  logic [CFG_W:0]        cfg_clamped;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign q_push    = accept;

  // A clear only counts on the first byte of a frame.
  assign clr_eff = in_tuser && (idx_r == '0);
  assign ws      = clr_eff ? '0 : wslot_r;
  assign hc      = clr_eff ? '0 : held_r;
  assign hc_inc  = {1'b0, hc} + (NW + 1)'(1);
  assign n       = (hc_inc > {1'b0, fiu_r}) ? fiu_r : hc_inc[NW-1:0];
  assign full    = (n == fiu_r);

  // Stored slots that contribute at this position; the slot being written
  // contributes the incoming pixel itself.
  always_comb begin
    for (int s = 0; s < MAX_FRAMES; s++) begin
      mask[s] = (NW'(s) < n) && (SW'(s) != ws) && !clr_eff &&
                (LW'(idx_r) < slot_len_r[s]);
    end
  end

  assign cfg_ext = {1'b0, cfg_wdata};
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_clamped = (CFG_W + 1)'(1);
    end else if (cfg_ext > (CFG_W + 1)'(MAX_FRAMES)) begin
      cfg_clamped = (CFG_W + 1)'(MAX_FRAMES);
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  always_comb begin
    fiu_nxt   = fiu_r;
    wslot_nxt = wslot_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    for (int s = 0; s < MAX_FRAMES; s++) begin
      slot_len_nxt[s] = slot_len_r[s];
    end
    if (cfg_we) begin
      fiu_nxt   = NW'(cfg_clamped);
      wslot_nxt = '0;
      held_nxt  = '0;
      idx_nxt   = '0;
      for (int s = 0; s < MAX_FRAMES; s++) begin
        slot_len_nxt[s] = '0;
      end
    end else if (accept) begin
      if (clr_eff) begin
        for (int s = 0; s < MAX_FRAMES; s++) begin
          slot_len_nxt[s] = '0;
        end
      end
      wslot_nxt = ws;
      held_nxt  = hc;
      if (in_tlast) begin
        slot_len_nxt[ws] = LW'(idx_r) + LW'(1);
        if (hc < fiu_r) begin
          held_nxt = hc + NW'(1);
        end
        if ((NW'(ws) + NW'(1)) == fiu_r) begin
          wslot_nxt = '0;
        end else begin
          wslot_nxt = ws + SW'(1);
        end
        idx_nxt = '0;
      end else if (idx_r != IW'(FRAME_BYTES - 1)) begin
        idx_nxt = idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r   <= NW'(FIU_RST);
      wslot_r <= '0;
      held_r  <= '0;
      idx_r   <= '0;
      for (int s = 0; s < MAX_FRAMES; s++) begin
        slot_len_r[s] <= '0;
      end
    end else begin
      fiu_r   <= fiu_nxt;
      wslot_r <= wslot_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      for (int s = 0; s < MAX_FRAMES; s++) begin
        slot_len_r[s] <= slot_len_nxt[s];
      end
    end
  end

  always_comb begin
    q_desc.pixel     = in_tdata;
    q_desc.index     = IDX_MAX_W'(idx_r);
    q_desc.slot      = SLOT_MAX_W'(ws);
    q_desc.use_mask  = MAX_FRAMES_LIM'(mask);
    q_desc.tag.count = CNT_MAX_W'(n);
    q_desc.tag.full  = full;
    q_desc.tag.eof   = in_tlast;
  end

endmodule

/* src/tfa_queue.sv */
module tfa_queue
  import tfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tfa_desc_t push_desc,
  output logic      ready,
  input  logic      pop,
  output logic      pop_valid,
  output tfa_desc_t pop_desc
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  tfa_desc_t     mem_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]   count_r,  count_nxt;
  logic          do_push;
  logic          do_pop;

  assign ready     = (count_r != (QW + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_desc  = mem_r[rd_ptr_r];
  assign do_push   = push && ready;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* src/tfa_back.sv */
module tfa_back
  import tfa_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  tfa_desc_t              q_desc,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam int NW     = $clog2(MAX_FRAMES + 1);
  localparam int IW     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int GROUPS = (MAX_FRAMES + 3) / 4;
  localparam int LANES  = GROUPS * 4;
  localparam int PW     = PIX_W + 2;
  localparam int SUM_W  = $clog2(MAX_FRAMES * 255 + 1);
  localparam int K      = SUM_W + NW;
  localparam int RC_W   = K + 1;
  localparam int PROD_W = SUM_W + RC_W;

  logic adv;

  logic [PIX_W-1:0] rd_data  [MAX_FRAMES];
  logic [PIX_W-1:0] rd_pad   [LANES];
  logic [LANES-1:0] mask_pad;
  logic [RC_W-1:0]  recip_tab [2**NW];

  logic                  a_valid_r;
  logic [PIX_W-1:0]      a_pixel_r;
  logic [MAX_FRAMES-1:0] a_mask_r;
  tfa_tag_t              a_tag_r;

  logic             b_valid_r;
  logic [PIX_W-1:0] b_pixel_r;
  logic [PW-1:0]    b_part_r   [GROUPS];
  logic [PW-1:0]    b_part_nxt [GROUPS];
  tfa_tag_t         b_tag_r;

  logic             c_valid_r;
  logic [SUM_W-1:0] c_sum_r, c_sum_nxt;
  tfa_tag_t         c_tag_r;

  logic              d_valid_r;
  logic [PROD_W-1:0] d_prod_r;
  tfa_tag_t          d_tag_r;

  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_mean_r;
  logic [HELD_OUT_W-1:0] out_held_r;
  logic                  out_full_r;
  logic                  out_eof_r;

  // The whole pipeline moves together whenever the output register can take a result.
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && q_valid;

  // One byte-wide store per slot. The slot being written is never read for
  // the same item, so its read-during-write value does not matter.
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_slot
    tfa_ram #(
      .WIDTH (PIX_W),
      .DEPTH (FRAME_BYTES)
    ) u_ram (
      .clk   (clk),
      .we    (q_pop && (q_desc.slot == SLOT_MAX_W'(g))),
      .waddr (q_desc.index[IW-1:0]),
      .wdata (q_desc.pixel),
      .re    (q_pop),
      .raddr (q_desc.index[IW-1:0]),
      .rdata (rd_data[g])
    );
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < MAX_FRAMES) begin : g_used
      assign rd_pad[g]   = rd_data[g];
      assign mask_pad[g] = a_mask_r[g];
    end else begin : g_pad
      assign rd_pad[g]   = '0;
      assign mask_pad[g] = 1'b0;
    end
  end

  // Reciprocals ceil(2^K / n); with K this large the product shifted down by
  // K is the exact floor of sum / n for every reachable sum.
  for (genvar g = 0; g < 2**NW; g++) begin : g_recip
    localparam int DIV = (g == 0) ? 1 : g;
    localparam int RC  = ((1 << K) + DIV - 1) / DIV;
    assign recip_tab[g] = RC_W'(RC);
  end

  always_comb begin
    for (int gi = 0; gi < GROUPS; gi++) begin
      b_part_nxt[gi] = '0;
      for (int j = 0; j < 4; j++) begin
        if (mask_pad[gi*4 + j]) begin
          b_part_nxt[gi] = b_part_nxt[gi] + PW'(rd_pad[gi*4 + j]);
        end
      end
    end
  end

  always_comb begin
    c_sum_nxt = SUM_W'(b_pixel_r);
    for (int gi = 0; gi < GROUPS; gi++) begin
      c_sum_nxt = c_sum_nxt + SUM_W'(b_part_r[gi]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pixel_r <= q_desc.pixel;
      a_mask_r  <= q_desc.use_mask[MAX_FRAMES-1:0];
      a_tag_r   <= q_desc.tag;

      b_pixel_r <= a_pixel_r;
      for (int gi = 0; gi < GROUPS; gi++) begin
        b_part_r[gi] <= b_part_nxt[gi];
      end
      b_tag_r <= a_tag_r;

      c_sum_r <= c_sum_nxt;
      c_tag_r <= b_tag_r;

      d_prod_r <= PROD_W'(c_sum_r) * PROD_W'(recip_tab[c_tag_r.count[NW-1:0]]);
      d_tag_r  <= c_tag_r;

      out_mean_r <= d_prod_r[K +: PIX_W];
      out_held_r <= d_tag_r.count[HELD_OUT_W-1:0];
      out_full_r <= d_tag_r.full;
      out_eof_r  <= d_tag_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - PIX_W - HELD_OUT_W)'(0), out_held_r, out_mean_r};
  assign out_tlast  = out_eof_r;
  assign out_tuser  = out_full_r;

endmodule

/* src/temporal_frame_average_unit.sv */
// Temporal frame averaging over a ring of stored frames.
//
// Pixels stream in on the in_ channel in raster order, one byte per transfer;
// in_tlast marks the last byte of a frame and in_tuser on a frame's first byte
// drops all held frames. For every input transfer exactly one result leaves
// on the out_ channel: the truncated mean of that position over the held
// frames and the new pixel, the number of frames in the mean, a history-full
// flag on out_tuser and the end-of-frame mark on out_tlast.
// A front end classifies each pixel against the ring state and puts it in a
// four-entry queue; the back end reads all slot memories at the pixel's
// position, writes the new pixel, adds the bytes in two registered steps and
// divides by a reciprocal multiply. The block takes one pixel per cycle
// while out_tready does not hold the back end, limited by the single read
// port of each slot memory. When out_tready is low the whole back end holds;
// the queue keeps accepting until it is full, and then in_tready drops.
// Reset empties the queue and the pipeline and restarts the history with
// frames_in_use at min(8, MAX_FRAMES); the frame memories are not cleared,
// since positions never written are masked out. cfg_we writes frames_in_use
// (0 reads as 1) and restarts the history; write it only while no pixel is
// in flight.
module temporal_frame_average_unit
  import tfa_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,   // frames_in_use
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,    // pixel [7:0]
  input  logic                   in_tlast,    // end_of_frame
  input  logic                   in_tuser,    // clear_history
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // mean_pixel [7:0], frames_held [11:8], zero
  output logic                   out_tlast,   // frame_done
  output logic                   out_tuser    // history_full
);

  logic      q_ready;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  tfa_desc_t push_desc;
  tfa_desc_t pop_desc;

  tfa_front #(
    .MAX_FRAMES  (MAX_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  // Decouples classification from the memory and arithmetic pipeline.
  tfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (pop_desc)
  );

  tfa_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_desc     (pop_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* src/tfa_checker.sv */
module tfa_checker
  import tfa_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // Reset empties the queue, so input is taken right after it.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind temporal_frame_average_unit tfa_checker u_checker (.*);
